### rtl/core/lru_key_value_cache_top_assert.svh
// Assertion macros for the LRU key-value cache.
// Used by lru_key_value_cache_top; expects i_clk and i_rst_n in scope.
`ifndef LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH

// same-cycle implication
`define LKV_AST_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lru cache: same-cycle check failed");

// next-cycle implication
`define LKV_AST_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lru cache: next-cycle check failed");

`endif

### rtl/core/lkv_pkg.sv
// Shared types and codes for the LRU key-value cache.
// No dependencies; used by lkv_cell and lru_key_value_cache_top.
package lkv_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CAP_W  = 5;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    typedef logic [WORD_W-1:0] t_word;

    // data handed from one cell to the next (toward older entries)
    typedef struct packed {
        logic  vld;    // left neighbor occupied
        logic  hit;    // a match seen at or before this point
        t_word key;    // key shifted in on update
        t_word data;   // data shifted in on update
        t_word rdata;  // OR of matching data so far
    } t_link;

    // broadcast control to every cell
    typedef struct packed {
        logic  upd;      // apply shift this cycle
        logic  any_hit;  // key found somewhere in the row
        logic  full;     // occupancy at or above capacity
        t_word key;      // request key
    } t_cell_ctl;

endpackage

### rtl/core/lkv_cell.sv
// One recency position of the LRU cache: holds valid, key and data.
// Depends on lkv_pkg.
module lkv_cell
    import lkv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_link     i_link,
    output t_link     o_link
);

    logic  r_vld;
    t_word r_key;
    t_word r_data;

    logic match;
    logic hit_run;
    logic shift;

    assign match   = r_vld && (r_key == i_ctl.key);
    assign hit_run = i_link.hit || match;

    // on a hit only the positions up to and including the match move
    always_comb begin
        if (i_ctl.any_hit) begin
            shift = !i_link.hit;
        end else if (i_ctl.full) begin
            shift = r_vld;
        end else begin
            shift = i_link.vld;
        end
    end

    assign o_link.vld   = r_vld;
    assign o_link.hit   = hit_run;
    assign o_link.key   = r_key;
    assign o_link.data  = r_data;
    assign o_link.rdata = i_link.rdata | (match ? r_data : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.upd && shift) begin
            r_vld <= i_link.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd && shift) begin
            r_key  <= i_link.key;
            r_data <= i_link.data;
        end
    end

endmodule

### rtl/core/lru_key_value_cache_top.sv
// LRU key-value cache: one item per cycle sustained unless a get waits on a stalled output.
// A get result is registered after the input register and the compare and shift in the cell row.
// The input register takes a new item in the same cycle the row executes the previous one.
// Reset (synchronous, active low) empties every cell; capacity returns to 16.
// Depends on lkv_pkg, lkv_cell and lru_key_value_cache_top_assert.svh.
module lru_key_value_cache_top
    import lkv_pkg::*;
#(
    parameter int unsigned ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_cmd,
    input  logic signed [31:0] i_key,
    input  logic signed [31:0] i_store_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_hit,
    output logic signed [31:0] o_read_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CAP_W-1:0]   i_cfg_data
);

`include "lru_key_value_cache_top_assert.svh"

    localparam int unsigned CW   = $clog2(ENTRIES + 1);
    localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;

    logic             r_req_vld;
    logic             r_cmd;
    t_word            r_key;
    t_word            r_val;
    logic [CAP_W-1:0] r_cap;
    logic [CW-1:0]    r_count;
    logic             r_out_vld;
    logic             r_hit;
    t_word            r_rdata;

    t_link        w_link [ENTRIES+1];
    logic [ENTRIES-1:0] w_vld;
    t_cell_ctl    ctl;
    logic         out_free;
    logic         exec;
    logic         in_acc;
    logic         any_hit;
    logic         full;
    logic         do_insert;
    logic [CMPW-1:0] eff_cap;

    // capacity clamped to 1..ENTRIES
    always_comb begin
        eff_cap = CMPW'(r_cap);
        if (r_cap == '0) begin
            eff_cap = CMPW'(1);
        end else if (CMPW'(r_cap) > CMPW'(ENTRIES)) begin
            eff_cap = CMPW'(ENTRIES);
        end
    end

    assign full      = CMPW'(r_count) >= eff_cap;
    assign any_hit   = w_link[ENTRIES].hit;
    assign out_free  = !r_out_vld || !i_out_stall;
    assign exec      = r_req_vld && ((r_cmd == CMD_SET) || out_free);
    assign in_acc    = i_in_valid && !o_in_stall;
    assign do_insert = exec && (r_cmd == CMD_SET) && !any_hit && !full;

    assign o_in_stall  = r_req_vld && !exec;
    assign o_cfg_ready = 1'b1;

    assign ctl.upd     = exec && ((r_cmd == CMD_SET) || any_hit);
    assign ctl.any_hit = any_hit;
    assign ctl.full    = full;
    assign ctl.key     = r_key;

    // head of the row: new most-recent entry
    assign w_link[0].vld   = 1'b1;
    assign w_link[0].hit   = 1'b0;
    assign w_link[0].key   = r_key;
    assign w_link[0].data  = (r_cmd == CMD_SET) ? r_val : w_link[ENTRIES].rdata;
    assign w_link[0].rdata = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lkv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1])
        );
        assign w_vld[g] = w_link[g+1].vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else if (in_acc) begin
            r_req_vld <= 1'b1;
        end else if (exec) begin
            r_req_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= i_cmd;
            r_key <= i_key;
            r_val <= i_store_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_W'(16);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (do_insert) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (exec && (r_cmd == CMD_GET)) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec && (r_cmd == CMD_GET)) begin
            r_hit   <= any_hit;
            r_rdata <= any_hit ? w_link[ENTRIES].rdata : '1;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_hit        = r_hit;
    assign o_read_value = r_rdata;

    `LKV_AST_IMP(a_count_max, 1'b1, r_count <= CW'(ENTRIES))
    `LKV_AST_IMP(a_vld_count, 1'b1, $countones(w_vld) == 32'(r_count))
    `LKV_AST_NXT(a_insert, do_insert, r_count == $past(r_count) + CW'(1))
    `LKV_AST_IMP(a_miss_val, o_out_valid && !o_hit, o_read_value == '1)

endmodule
